@@ design/cwr_pkg.sv @@
// Shared types and constants for the glyph width run encoder.
// Used by the controller, the datapath and the top level; depends on nothing.
`default_nettype none

package cwr_pkg;

    localparam int ACTION_W = 2;
    localparam int CODE_W   = 16;
    localparam int GLYPH_W  = 16;
    localparam int KIND_W   = 2;

    localparam logic [ACTION_W-1:0] ACT_DEFAULT = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_GLYPH   = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_FLUSH   = 2'd2;

    localparam logic [KIND_W-1:0] KIND_DEFAULT = 2'd0;
    localparam logic [KIND_W-1:0] KIND_RANGE   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_LIST    = 2'd2;

    localparam logic [CODE_W-1:0] CODE_MAX = 16'hFFFF;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EVAL,
        S_EMIT,
        S_RANGE,
        S_LRD,
        S_LOUT,
        S_START
    } t_state;

    typedef struct packed {
        logic cap;
        logic set_font;
        logic append;
        logic start_run;
        logic clear_run;
        logic close_font;
        logic load_range;
        logic load_list;
        logic rd_en;
        logic idx_clr;
        logic idx_inc;
    } t_cmd;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic                font_open;
        logic                is_default;
        logic                can_continue;
        logic                full_after_append;
        logic                len_zero;
        logic                all_same;
        logic                idx_last;
        logic                out_free;
    } t_sts;

endpackage

`default_nettype wire

@@ design/cid_width_run_encoder.sv @@
// Top level of the glyph width run encoder: stream ports, controller and datapath.
// Depends on cwr_pkg, cwr_ctrl, cwr_dp and cwr_ram.
//
// Glyph transactions arrive in code order and are handled one at a time. A default
// glyph, a dropped glyph or a glyph that extends the current run is accepted, then
// evaluated; a glyph that breaks a run adds the emission of the old run and a step
// to start the new one. A run of equal widths leaves as one range transaction
// (emit, then range state); a mixed run leaves its list elements one at a time,
// each read first through the single registered read port of the width buffer.
// Output backpressure stretches any emission step. The output register lets the
// next glyph be accepted while the last result still waits to be taken.
`default_nettype none

module cid_width_run_encoder #(
    parameter int RUN_MAX = 32
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [31:0] s_axis_tdata,  // code [15:0], glyph_width [31:16]
    input  wire logic [1:0]  s_axis_tuser,  // action [1:0]
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [47:0]      m_axis_tdata,  // first_code [15:0], last_code [31:16],
                                            // width_value [47:32]
    output logic [1:0]       m_axis_tuser,  // kind [1:0]
    output logic             m_axis_tlast   // last_of_run
);

    cwr_pkg::t_cmd cmd;
    cwr_pkg::t_sts sts;

    logic [cwr_pkg::CODE_W-1:0]          out_first;
    logic [cwr_pkg::CODE_W-1:0]          out_last;
    logic signed [cwr_pkg::GLYPH_W-1:0]  out_width;

    cwr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_sts      (sts),
        .o_in_ready (s_axis_tready),
        .o_cmd      (cmd)
    );

    cwr_dp #(
        .RUN_MAX (RUN_MAX)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_action      (s_axis_tuser),
        .i_code        (s_axis_tdata[15:0]),
        .i_glyph_width (s_axis_tdata[31:16]),
        .i_out_ready   (m_axis_tready),
        .o_sts         (sts),
        .o_out_valid   (m_axis_tvalid),
        .o_kind        (m_axis_tuser),
        .o_first_code  (out_first),
        .o_last_code   (out_last),
        .o_width_value (out_width),
        .o_last_of_run (m_axis_tlast)
    );

    assign m_axis_tdata = {out_width, out_last, out_first};

endmodule

`default_nettype wire

@@ design/cwr_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// Self-contained; used by the datapath for the run width buffer.
`default_nettype none

module cwr_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

@@ design/cwr_ctrl.sv @@
// Controller state machine of the glyph width run encoder.
// Depends on cwr_pkg for the state type and the command and status structs.
`default_nettype none

module cwr_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    input  wire cwr_pkg::t_sts i_sts,
    output logic               o_in_ready,
    output cwr_pkg::t_cmd      o_cmd
);

    cwr_pkg::t_state r_state;
    cwr_pkg::t_state n_state;
    logic            r_then_start;
    logic            n_then_start;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= cwr_pkg::S_IDLE;
            r_then_start <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_then_start <= n_then_start;
        end
    end

    always_comb begin
        n_state      = r_state;
        n_then_start = r_then_start;
        unique case (r_state)
            cwr_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_state = cwr_pkg::S_EVAL;
                end
            end
            cwr_pkg::S_EVAL: begin
                n_then_start = 1'b0;
                unique case (i_sts.action)
                    cwr_pkg::ACT_DEFAULT: begin
                        if (i_sts.out_free) begin
                            n_state = cwr_pkg::S_IDLE;
                        end
                    end
                    cwr_pkg::ACT_GLYPH: begin
                        if (!i_sts.font_open || i_sts.is_default) begin
                            n_state = cwr_pkg::S_IDLE;
                        end else if (i_sts.can_continue) begin
                            n_state = i_sts.full_after_append ? cwr_pkg::S_EMIT
                                                              : cwr_pkg::S_IDLE;
                        end else begin
                            n_state      = cwr_pkg::S_EMIT;
                            n_then_start = 1'b1;
                        end
                    end
                    cwr_pkg::ACT_FLUSH: begin
                        n_state = i_sts.font_open ? cwr_pkg::S_EMIT : cwr_pkg::S_IDLE;
                    end
                    default: begin
                        n_state = cwr_pkg::S_IDLE;
                    end
                endcase
            end
            cwr_pkg::S_EMIT: begin
                if (i_sts.len_zero) begin
                    n_state = r_then_start ? cwr_pkg::S_START : cwr_pkg::S_IDLE;
                end else if (i_sts.all_same) begin
                    n_state = cwr_pkg::S_RANGE;
                end else begin
                    n_state = cwr_pkg::S_LRD;
                end
            end
            cwr_pkg::S_RANGE: begin
                if (i_sts.out_free) begin
                    n_state = r_then_start ? cwr_pkg::S_START : cwr_pkg::S_IDLE;
                end
            end
            cwr_pkg::S_LRD: begin
                n_state = cwr_pkg::S_LOUT;
            end
            cwr_pkg::S_LOUT: begin
                if (i_sts.out_free) begin
                    if (i_sts.idx_last) begin
                        n_state = r_then_start ? cwr_pkg::S_START : cwr_pkg::S_IDLE;
                    end else begin
                        n_state = cwr_pkg::S_LRD;
                    end
                end
            end
            cwr_pkg::S_START: begin
                n_state = cwr_pkg::S_IDLE;
            end
            default: begin
                n_state = cwr_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_in_ready = 1'b0;
        o_cmd      = '0;
        unique case (r_state)
            cwr_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.cap  = i_in_valid;
            end
            cwr_pkg::S_EVAL: begin
                unique case (i_sts.action)
                    cwr_pkg::ACT_DEFAULT: begin
                        o_cmd.set_font = i_sts.out_free;
                    end
                    cwr_pkg::ACT_GLYPH: begin
                        o_cmd.append = i_sts.font_open && !i_sts.is_default &&
                                       i_sts.can_continue;
                    end
                    cwr_pkg::ACT_FLUSH: begin
                        o_cmd.close_font = i_sts.font_open;
                    end
                    default: begin
                    end
                endcase
            end
            cwr_pkg::S_EMIT: begin
                o_cmd.idx_clr = 1'b1;
            end
            cwr_pkg::S_RANGE: begin
                o_cmd.load_range = i_sts.out_free;
                o_cmd.clear_run  = i_sts.out_free;
            end
            cwr_pkg::S_LRD: begin
                o_cmd.rd_en = 1'b1;
            end
            cwr_pkg::S_LOUT: begin
                o_cmd.load_list = i_sts.out_free;
                o_cmd.clear_run = i_sts.out_free && i_sts.idx_last;
                o_cmd.idx_inc   = i_sts.out_free && !i_sts.idx_last;
            end
            cwr_pkg::S_START: begin
                o_cmd.start_run = 1'b1;
            end
            default: begin
            end
        endcase
    end

endmodule

`default_nettype wire

@@ design/cwr_dp.sv @@
// Datapath of the glyph width run encoder: input item, run state, width buffer
// and output register. Depends on cwr_pkg and cwr_ram.
`default_nettype none

module cwr_dp #(
    parameter int RUN_MAX = 32
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire cwr_pkg::t_cmd                 i_cmd,
    input  wire logic [cwr_pkg::ACTION_W-1:0]  i_action,
    input  wire logic [cwr_pkg::CODE_W-1:0]    i_code,
    input  wire logic signed [cwr_pkg::GLYPH_W-1:0] i_glyph_width,
    input  wire logic                          i_out_ready,
    output cwr_pkg::t_sts                      o_sts,
    output logic                               o_out_valid,
    output logic [cwr_pkg::KIND_W-1:0]         o_kind,
    output logic [cwr_pkg::CODE_W-1:0]         o_first_code,
    output logic [cwr_pkg::CODE_W-1:0]         o_last_code,
    output logic signed [cwr_pkg::GLYPH_W-1:0] o_width_value,
    output logic                               o_last_of_run
);

    localparam int LW = $clog2(RUN_MAX + 1);
    localparam int AW = $clog2(RUN_MAX);

    logic [cwr_pkg::ACTION_W-1:0]        r_action;
    logic [cwr_pkg::CODE_W-1:0]          r_code;
    logic signed [cwr_pkg::GLYPH_W-1:0]  r_width;
    logic signed [cwr_pkg::GLYPH_W-1:0]  r_default;
    logic [cwr_pkg::CODE_W-1:0]          r_first_code;
    logic [cwr_pkg::CODE_W-1:0]          r_prev_code;
    logic signed [cwr_pkg::GLYPH_W-1:0]  r_first_width;
    logic                                r_all_same;
    logic [LW-1:0]                       r_len;
    logic                                r_font_open;
    logic [AW-1:0]                       r_idx;

    logic                                r_out_valid;
    logic [cwr_pkg::KIND_W-1:0]          r_out_kind;
    logic [cwr_pkg::CODE_W-1:0]          r_out_first;
    logic [cwr_pkg::CODE_W-1:0]          r_out_last;
    logic signed [cwr_pkg::GLYPH_W-1:0]  r_out_width;
    logic                                r_out_tlast;

    logic                                ram_wr_en;
    logic [AW-1:0]                       ram_wr_addr;
    logic [cwr_pkg::GLYPH_W-1:0]         ram_rd_data;
    logic                                out_free;
    logic                                idx_last;

    assign out_free    = !r_out_valid || i_out_ready;
    assign idx_last    = (LW'(r_idx) + LW'(1)) == r_len;
    assign ram_wr_en   = i_cmd.append || i_cmd.start_run;
    assign ram_wr_addr = i_cmd.start_run ? '0 : r_len[AW-1:0];

    cwr_ram #(
        .WIDTH (cwr_pkg::GLYPH_W),
        .DEPTH (RUN_MAX)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (ram_wr_addr),
        .i_wr_data (r_width),
        .i_rd_en   (i_cmd.rd_en),
        .i_rd_addr (r_idx),
        .o_rd_data (ram_rd_data)
    );

    always_comb begin
        o_sts                   = '0;
        o_sts.action            = r_action;
        o_sts.font_open         = r_font_open;
        o_sts.is_default        = r_width == r_default;
        o_sts.can_continue      = (r_len != '0) && (r_prev_code != cwr_pkg::CODE_MAX) &&
                                  (r_code == r_prev_code + 16'd1) &&
                                  (r_len < LW'(RUN_MAX));
        o_sts.full_after_append = (r_len + LW'(1)) == LW'(RUN_MAX);
        o_sts.len_zero          = r_len == '0;
        o_sts.all_same          = r_all_same;
        o_sts.idx_last          = idx_last;
        o_sts.out_free          = out_free;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.cap) begin
            r_action <= i_action;
            r_code   <= i_code;
            r_width  <= i_glyph_width;
        end
        if (i_cmd.start_run) begin
            r_first_width <= r_width;
        end
        if (i_cmd.idx_clr) begin
            r_idx <= '0;
        end else if (i_cmd.idx_inc) begin
            r_idx <= r_idx + AW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_default    <= '0;
            r_first_code <= '0;
            r_prev_code  <= '0;
            r_all_same   <= 1'b1;
            r_len        <= '0;
            r_font_open  <= 1'b0;
        end else begin
            if (i_cmd.set_font) begin
                r_default   <= r_width;
                r_font_open <= 1'b1;
                r_len       <= '0;
                r_all_same  <= 1'b1;
            end
            if (i_cmd.close_font) begin
                r_font_open <= 1'b0;
            end
            if (i_cmd.clear_run) begin
                r_len      <= '0;
                r_all_same <= 1'b1;
            end
            if (i_cmd.append) begin
                r_prev_code <= r_code;
                r_len       <= r_len + LW'(1);
                if (r_width != r_first_width) begin
                    r_all_same <= 1'b0;
                end
            end
            if (i_cmd.start_run) begin
                r_first_code <= r_code;
                r_prev_code  <= r_code;
                r_len        <= LW'(1);
                r_all_same   <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.set_font || i_cmd.load_range || i_cmd.load_list) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.set_font) begin
            r_out_kind  <= cwr_pkg::KIND_DEFAULT;
            r_out_first <= r_code;
            r_out_last  <= r_code;
            r_out_width <= r_width;
            r_out_tlast <= 1'b1;
        end else if (i_cmd.load_range) begin
            r_out_kind  <= cwr_pkg::KIND_RANGE;
            r_out_first <= r_first_code;
            r_out_last  <= r_prev_code;
            r_out_width <= r_first_width;
            r_out_tlast <= 1'b1;
        end else if (i_cmd.load_list) begin
            r_out_kind  <= cwr_pkg::KIND_LIST;
            r_out_first <= r_first_code;
            r_out_last  <= '0;
            r_out_width <= ram_rd_data;
            r_out_tlast <= idx_last;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_kind        = r_out_kind;
    assign o_first_code  = r_out_first;
    assign o_last_code   = r_out_last;
    assign o_width_value = r_out_width;
    assign o_last_of_run = r_out_tlast;

`ifndef SYNTH
    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len <= LW'(RUN_MAX))
        else $error("Run length exceeds the buffer depth.");

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.set_font || i_cmd.load_range || i_cmd.load_list) |->
        (out_free && $onehot0({i_cmd.set_font, i_cmd.load_range, i_cmd.load_list})))
        else $error("Output register loaded while occupied or by two sources.");

    a_append_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.append |-> (r_font_open && r_len != '0 && r_len < LW'(RUN_MAX)))
        else $error("Width appended outside an open, non-full run.");

    a_list_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load_list |-> (LW'(r_idx) < r_len && !r_all_same))
        else $error("List element read beyond the run.");
`endif

endmodule

`default_nettype wire

@@ test/cid_width_run_encoder_tb.sv @@
// Self-checking testbench for the glyph width run encoder: directed font sequences,
// then random fonts under three pacing phases, checked against an internal run predictor.
// Depends on cwr_pkg and cid_width_run_encoder.
`default_nettype none

module cid_width_run_encoder_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RUN_LEN_MAX  = 32;
    localparam int SETTLE_CYCLES = 40;
    localparam int MAX_REPORTS   = 40;

    localparam logic [cwr_pkg::ACTION_W-1:0] ACT_UNUSED = 2'd3;

    typedef struct {
        logic [cwr_pkg::KIND_W-1:0]  kind;
        logic [cwr_pkg::CODE_W-1:0]  first_code;
        logic [cwr_pkg::CODE_W-1:0]  last_code;
        logic [cwr_pkg::GLYPH_W-1:0] width_value;
        logic                        last_of_run;
    } t_width_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;  // code [15:0], glyph_width [31:16]
    logic [1:0]  s_axis_tuser = '0;  // action [1:0]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;       // first_code [15:0], last_code [31:16], width_value [47:32]
    logic [1:0]  m_axis_tuser;       // kind [1:0]
    logic        m_axis_tlast;

    t_width_result width_results_q[$];
    t_width_result got_result;
    t_width_result want_result;

    logic [cwr_pkg::GLYPH_W-1:0] dflt_width = '0;
    logic [cwr_pkg::CODE_W-1:0]  run_start = '0;
    logic [cwr_pkg::CODE_W-1:0]  run_end = '0;
    logic                        run_uniform = 1'b1;
    int                          run_len = 0;
    logic [cwr_pkg::GLYPH_W-1:0] run_buf [RUN_LEN_MAX];
    logic                        font_active = 1'b0;

    int src_idle_pct = 0;
    int snk_idle_pct = 0;
    int error_count = 0;
    int glyphs_sent = 0;
    int results_seen = 0;
    int fonts_sent = 0;

    cid_width_run_encoder #(
        .RUN_MAX(RUN_LEN_MAX)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tuser(m_axis_tuser),
        .m_axis_tlast(m_axis_tlast)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #5ms;
        $display("TEST FAILED");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        if (error_count < MAX_REPORTS) begin
            $display("[%0t] mismatch: %s", $realtime, msg);
        end
        error_count++;
    endtask

    task automatic push_result(input logic [cwr_pkg::KIND_W-1:0] kind,
                               input logic [cwr_pkg::CODE_W-1:0] first,
                               input logic [cwr_pkg::CODE_W-1:0] last,
                               input logic [cwr_pkg::GLYPH_W-1:0] w,
                               input logic tl);
        t_width_result r;
        r.kind = kind;
        r.first_code = first;
        r.last_code = last;
        r.width_value = w;
        r.last_of_run = tl;
        width_results_q.insert(width_results_q.size(), r);
    endtask

    task automatic emit_pending_run();
        if (run_len > 0) begin
            if (run_uniform) begin
                push_result(cwr_pkg::KIND_RANGE, run_start, run_end, run_buf[0], 1'b1);
            end else begin
                for (int i = 0; i < run_len; i++) begin
                    push_result(cwr_pkg::KIND_LIST, run_start, 16'd0, run_buf[i],
                                i == run_len - 1);
                end
            end
        end
        run_len = 0;
        run_uniform = 1'b1;
    endtask

    task automatic predict_widths(input logic [cwr_pkg::ACTION_W-1:0] act,
                                  input logic [cwr_pkg::CODE_W-1:0] code,
                                  input logic [cwr_pkg::GLYPH_W-1:0] w);
        logic [cwr_pkg::CODE_W-1:0] next_code;
        next_code = run_end + 16'd1;
        case (act)
            cwr_pkg::ACT_DEFAULT: begin
                run_len = 0;
                run_uniform = 1'b1;
                dflt_width = w;
                font_active = 1'b1;
                push_result(cwr_pkg::KIND_DEFAULT, code, code, w, 1'b1);
            end
            cwr_pkg::ACT_GLYPH: begin
                if (font_active && w != dflt_width) begin
                    if (run_len > 0 && run_end != cwr_pkg::CODE_MAX && code == next_code &&
                        run_len < RUN_LEN_MAX) begin
                        run_end = code;
                        if (run_buf[0] != w) run_uniform = 1'b0;
                        run_buf[run_len] = w;
                        run_len++;
                    end else begin
                        emit_pending_run();
                        run_start = code;
                        run_end = code;
                        run_buf[0] = w;
                        run_len = 1;
                        run_uniform = 1'b1;
                    end
                    if (run_len >= RUN_LEN_MAX) emit_pending_run();
                end
            end
            cwr_pkg::ACT_FLUSH: begin
                if (font_active) begin
                    emit_pending_run();
                    font_active = 1'b0;
                end
            end
            default: begin
            end
        endcase
    endtask

    task automatic send_glyph(input logic [cwr_pkg::ACTION_W-1:0] act,
                              input logic [cwr_pkg::CODE_W-1:0] code,
                              input logic [cwr_pkg::GLYPH_W-1:0] w);
        while ($urandom_range(99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {w, code};
        s_axis_tuser <= act;
        do @(posedge i_clk); while (!s_axis_tready);
        predict_widths(act, code, w);
        glyphs_sent++;
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (width_results_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            results_seen++;
            got_result.kind = m_axis_tuser;
            got_result.first_code = m_axis_tdata[15:0];
            got_result.last_code = m_axis_tdata[31:16];
            got_result.width_value = m_axis_tdata[47:32];
            got_result.last_of_run = m_axis_tlast;
            if (width_results_q.size() == 0) begin
                report_mismatch($sformatf("unexpected result kind %0d first %h",
                                          got_result.kind, got_result.first_code));
            end else begin
                want_result = width_results_q.pop_front();
                if (got_result.kind != want_result.kind)
                    report_mismatch($sformatf("kind %0d, wanted %0d",
                                              got_result.kind, want_result.kind));
                if (got_result.first_code != want_result.first_code)
                    report_mismatch($sformatf("first_code %h, wanted %h",
                                              got_result.first_code, want_result.first_code));
                if (got_result.last_code != want_result.last_code)
                    report_mismatch($sformatf("last_code %h, wanted %h",
                                              got_result.last_code, want_result.last_code));
                if (got_result.width_value != want_result.width_value)
                    report_mismatch($sformatf("width_value %h, wanted %h",
                                              got_result.width_value, want_result.width_value));
                if (got_result.last_of_run != want_result.last_of_run)
                    report_mismatch($sformatf("last_of_run %0b, wanted %0b",
                                              got_result.last_of_run, want_result.last_of_run));
            end
        end
        m_axis_tready <= ($urandom_range(99) >= snk_idle_pct);
    end

    function automatic logic [cwr_pkg::CODE_W-1:0] pick_code();
        case ($urandom_range(0, 9))
            0: return cwr_pkg::CODE_MAX - 16'($urandom_range(0, 40));
            1: return 16'($urandom);
            default: return 16'($urandom_range(0, 2000));
        endcase
    endfunction

    function automatic logic [cwr_pkg::GLYPH_W-1:0] pick_width();
        case ($urandom_range(0, 9))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2, 3: return 16'($urandom);
            default: return 16'($urandom_range(0, 1500));
        endcase
    endfunction

    task automatic test_no_font_ignored();
        send_glyph(cwr_pkg::ACT_GLYPH, 16'd5, 16'd7);
        send_glyph(cwr_pkg::ACT_FLUSH, 16'hFFFF, 16'hFFFF);
        send_glyph(ACT_UNUSED, 16'h1234, 16'h5678);
    endtask

    task automatic test_ranges_and_lists();
        send_glyph(cwr_pkg::ACT_DEFAULT, 16'd0, 16'h8000);
        send_glyph(cwr_pkg::ACT_GLYPH, 16'd1, 16'h8000);
        send_glyph(cwr_pkg::ACT_GLYPH, 16'd1, 16'h7FFF);
        send_glyph(cwr_pkg::ACT_GLYPH, 16'd2, 16'h7FFF);
        send_glyph(cwr_pkg::ACT_GLYPH, 16'd3, 16'h7FFF);
        send_glyph(cwr_pkg::ACT_GLYPH, 16'd4, 16'h8000);
        send_glyph(cwr_pkg::ACT_GLYPH, 16'd5, 16'h0001);
        send_glyph(cwr_pkg::ACT_GLYPH, 16'd6, 16'hFFFF);
        send_glyph(cwr_pkg::ACT_FLUSH, 16'd0, 16'd0);
        wait_drained();
    endtask

    task automatic test_code_limit();
        send_glyph(cwr_pkg::ACT_DEFAULT, 16'hFFFE, 16'd0);
        send_glyph(cwr_pkg::ACT_GLYPH, 16'hFFFE, 16'd5);
        send_glyph(cwr_pkg::ACT_GLYPH, 16'hFFFF, 16'd5);
        send_glyph(cwr_pkg::ACT_GLYPH, 16'd0, 16'd6);
        send_glyph(cwr_pkg::ACT_GLYPH, 16'hFFFF, 16'd1);
        send_glyph(cwr_pkg::ACT_GLYPH, 16'd0, 16'd1);
        send_glyph(cwr_pkg::ACT_FLUSH, 16'd0, 16'd0);
    endtask

    task automatic test_new_font_discard();
        send_glyph(cwr_pkg::ACT_DEFAULT, 16'd10, 16'd3);
        send_glyph(cwr_pkg::ACT_GLYPH, 16'd11, 16'd4);
        send_glyph(cwr_pkg::ACT_GLYPH, 16'd12, 16'd9);
        send_glyph(cwr_pkg::ACT_DEFAULT, 16'd20, 16'd0);
        send_glyph(cwr_pkg::ACT_FLUSH, 16'd0, 16'd0);
        wait_drained();
    endtask

    task automatic random_font();
        logic [cwr_pkg::CODE_W-1:0]  code;
        logic [cwr_pkg::GLYPH_W-1:0] w_dflt;
        logic [cwr_pkg::GLYPH_W-1:0] w_a;
        logic [cwr_pkg::GLYPH_W-1:0] w_b;
        logic [cwr_pkg::GLYPH_W-1:0] w;
        int segs;
        int len;
        int mode;
        int ending;
        code = pick_code();
        w_dflt = pick_width();
        w_a = pick_width();
        w_b = pick_width();
        send_glyph(cwr_pkg::ACT_DEFAULT, code, w_dflt);
        segs = $urandom_range(1, 6);
        for (int s = 0; s < segs; s++) begin
            if ($urandom_range(99) < 40) code = code + 16'd1;
            else code = code + 16'($urandom_range(2, 300));
            len = ($urandom_range(99) < 10) ? $urandom_range(28, 40) : $urandom_range(1, 8);
            mode = $urandom_range(0, 2);
            for (int j = 0; j < len; j++) begin
                case (mode)
                    0: w = w_a;
                    1: w = ($urandom_range(0, 2) == 0) ? 16'($urandom) :
                           (($urandom_range(0, 1) == 0) ? w_a : w_b);
                    default: w = ($urandom_range(0, 3) == 0) ? w_dflt : w_a;
                endcase
                if ($urandom_range(99) < 3) begin
                    if ($urandom_range(0, 1) == 0)
                        send_glyph(ACT_UNUSED, 16'($urandom), 16'($urandom));
                    else
                        send_glyph(cwr_pkg::ACT_GLYPH, 16'($urandom), 16'($urandom));
                end
                send_glyph(cwr_pkg::ACT_GLYPH, code, w);
                if (j != len - 1) code = code + 16'd1;
            end
        end
        ending = $urandom_range(99);
        if (ending < 85) begin
            send_glyph(cwr_pkg::ACT_FLUSH, 16'($urandom), 16'($urandom));
        end else if (ending < 93) begin
            send_glyph(cwr_pkg::ACT_FLUSH, 16'($urandom), 16'($urandom));
            send_glyph(cwr_pkg::ACT_GLYPH, 16'($urandom), 16'($urandom));
            send_glyph(cwr_pkg::ACT_FLUSH, 16'($urandom), 16'($urandom));
        end
        fonts_sent++;
    endtask

    task automatic test_random_traffic(input int src_pct, input int snk_pct, input int n_items);
        int target;
        target = glyphs_sent + n_items;
        src_idle_pct = src_pct;
        snk_idle_pct = snk_pct;
        while (glyphs_sent < target) begin
            random_font();
            if ($urandom_range(0, 7) == 0) wait_drained();
        end
    endtask

    initial begin
        src_idle_pct = 30;
        snk_idle_pct = 30;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_no_font_ignored();
        test_ranges_and_lists();
        test_code_limit();
        test_new_font_discard();
        test_random_traffic(22, 78, 170);
        test_random_traffic(78, 22, 170);
        test_random_traffic(0, 0, 170);

        s_axis_tvalid <= 1'b0;
        while (width_results_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("Sent %0d glyph transactions in %0d random fonts plus directed cases;",
                 glyphs_sent, fonts_sent);
        $display("checked %0d result transactions under three pacing phases.", results_seen);
        if (error_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire
